>>> hw/rtl/mfd_pkg.sv
// meter frame decoder: shared types and constants
// no dependencies; imported by every other source file

package mfd_pkg;

  localparam int unsigned FRAME_LEN      = 8;
  localparam int unsigned CURRENT_OFFSET = 3;
  localparam logic [31:0] COUNT_MID      = 32'h0100_0000;

  // range codes carried in frame byte 4
  localparam logic [7:0] RANGE_2V    = 8'd0;
  localparam logic [7:0] RANGE_200MV = 8'd1;
  localparam logic [7:0] RANGE_20MV  = 8'd2;

  // divisor 144888 / k, k = 100, 10, 1
  localparam int unsigned DIV_W       = 18;
  localparam logic [DIV_W-1:0] DIV_BASE = 18'd144888;
  localparam logic [DIV_W-2:0] DIV_HALF = 17'd72444;
  localparam logic [6:0]  K_2V        = 7'd100;
  localparam logic [6:0]  K_200MV     = 7'd10;
  localparam logic [6:0]  K_20MV      = 7'd1;

  // 144888 = 8 * 18111: reciprocal of the odd part, 36-bit shift
  localparam int unsigned DIV_ODD     = 18111;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD);

  localparam int unsigned SCALED_W = 49;
  localparam int unsigned COUNT_W  = 33;
  localparam logic [SCALED_W-1:0] SCALED_MAX_MAG = 49'h1_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_K100,
    MODE_K10,
    MODE_K1,
    MODE_RAW
  } scale_mode_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] adc_range;
    logic [7:0] range_index;
    logic       current_valid;
    logic [7:0] current_code;
  } mfd_side_t;

endpackage

>>> hw/rtl/meter_frame_decoder_top.sv
// meter frame decoder top level: frame assembly, checksum and result packing
// depends on mfd_pkg and mfd_scale
//
// channel | dir | tdata (low bit first)                               | tuser
// in_     | in  | rx_byte[7:0]                                        | frame_start
// out_    | out | signed_count[32:0] scaled_volts[48:0] adc_range[7:0] | frame_ok
//         |     | range_index[7:0] current_valid current_code[7:0] pad |
//
// one byte per cycle while in_tready is high; out_tvalid rises once a frame's
// eighth byte is through 8 divider stages (two corrected reciprocal multiplies)
// reset clears the byte position and every pipeline valid; frame bytes are
// left as they are until written
// a stalled output holds its transfer, empty stages close up behind it, and
// in_tready falls only when every stage of the divider holds a result

module meter_frame_decoder_top
  import mfd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // rx_byte[7:0]
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // signed_count, scaled_volts, adc_range,
                                   // range_index, current_valid, current_code, zero pad
  output logic         out_tuser   // frame_ok
);

  logic [3:0] pos_r;
  logic [7:0] byte_r [7];
  logic [7:0] sum_r;

  logic       accept;
  logic [3:0] eff_pos;
  logic       store;
  logic       frame_done;
  logic       checksum_ok;
  logic [31:0] cnt;
  logic [31:0] mag;
  mfd_side_t  side;

  logic                       scl_ready;
  logic signed [COUNT_W-1:0]  scl_count;
  logic signed [SCALED_W-1:0] scl_scaled;
  mfd_side_t                  scl_side;

  assign accept  = in_tvalid && in_tready;
  // a start flag makes this byte frame byte zero
  assign eff_pos = in_tuser ? 4'd0 : pos_r;
  assign store   = accept && (eff_pos < 4'(FRAME_LEN - 1));
  assign frame_done = accept && (eff_pos == 4'(FRAME_LEN - 1));

  // running sum of bytes 0..6 against the complement of byte 7
  assign checksum_ok = (sum_r == ~in_tdata);

  // big-endian count, folded about the mid-scale point
  assign cnt = {byte_r[0], byte_r[1], byte_r[2], byte_r[3]};
  always_comb begin
    mag  = '0;
    side = '0;
    if (checksum_ok) begin
      mag = (cnt > COUNT_MID) ? cnt - COUNT_MID : COUNT_MID - cnt;
      side.frame_ok      = 1'b1;
      side.adc_range     = byte_r[4];
      side.range_index   = byte_r[5] - 8'd1;
      side.current_valid = byte_r[6] >= 8'(CURRENT_OFFSET);
      if (side.current_valid) begin
        side.current_code = byte_r[6] - 8'(CURRENT_OFFSET);
      end
    end
  end

  // byte position saturates at the frame length until the next start flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      if (eff_pos < 4'(FRAME_LEN - 1)) begin
        pos_r <= eff_pos + 4'd1;
      end else begin
        pos_r <= 4'(FRAME_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      byte_r[eff_pos[2:0]] <= in_tdata;
      sum_r <= (eff_pos == 4'd0) ? in_tdata : sum_r + in_tdata;
    end
  end

  mfd_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frame_done),
    .in_ready   (scl_ready),
    .in_mag     (mag),
    .in_side    (side),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_count  (scl_count),
    .out_scaled (scl_scaled),
    .out_side   (scl_side)
  );

  // every byte waits on the first divider stage, so result order is kept
  assign in_tready = scl_ready;

  assign out_tdata = {5'd0, scl_side.current_code, scl_side.current_valid,
                      scl_side.range_index, scl_side.adc_range,
                      scl_scaled, scl_count};
  assign out_tuser = scl_side.frame_ok;

  // checks

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 4'(FRAME_LEN))
    else $error("byte position beyond frame length");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !scl_side.frame_ok |->
      scl_count == '0 && scl_scaled == '0 && scl_side == '0)
    else $error("rejected frame carries non-zero fields");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (scl_scaled[SCALED_W-1] || scl_scaled == '0) &&
                   (scl_count[COUNT_W-1] || scl_count == '0))
    else $error("count or scaled value positive");

  a_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !scl_side.current_valid |-> scl_side.current_code == '0)
    else $error("current code set without valid current");

endmodule

>>> hw/rtl/mfd_scale.sv
// meter frame decoder: elastic pipeline that negates the count and scales it
// by the range divisor, or passes it unscaled for other range codes; depends on mfd_pkg

module mfd_scale
  import mfd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_mag,
  input  mfd_side_t                  in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [COUNT_W-1:0]  out_count,
  output logic signed [SCALED_W-1:0] out_scaled,
  output mfd_side_t                  out_side
);

  localparam int unsigned NSTG   = 8;
  localparam int unsigned PROD_W = 39;
  localparam int unsigned QUO_W  = 22;
  localparam int unsigned REM_W  = DIV_W + 1;
  localparam int unsigned NUM_W  = DIV_W + 1 + FRAC_BITS;
  localparam int unsigned EST_W  = FRAC_BITS + 2;
  localparam int unsigned ZW     = NUM_W - 3;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic [31:0]     mag_r  [NSTG];
  scale_mode_t     mode_r [NSTG];
  mfd_side_t       side_r [NSTG];

  logic [PROD_W-1:0] prod1_r, prod2_r;
  logic [QUO_W-1:0]  quo2_r, quo3_r, quo4_r, quo5_r, quo6_r;
  logic [REM_W-1:0]  rem3_r, rem6_r;
  logic [NUM_W-1:0]  num4_r, num5_r;
  logic [EST_W-1:0]  est5_r, est6_r;
  logic [SCALED_W-1:0] scaled7_r;

  scale_mode_t         mode0_nxt;
  logic [6:0]          kval;
  logic [PROD_W-1:0]   prod1_nxt;
  logic [57:0]         recip2_p;
  logic [QUO_W+DIV_W-1:0] diff3;
  logic                ge4;
  logic [REM_W-1:0]    rmd4;
  logic [NUM_W-1:0]    num4_nxt;
  logic [ZW+RECIP_W-1:0] recip5_p;
  logic [EST_W+DIV_W-1:0] diff6;
  logic [EST_W-1:0]    est7;
  logic [SCALED_W-1:0] qdiv7, q7;

  // ready ripples back from the output; a stage loads when it is free or the next is ready
  assign rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
  for (genvar g = 0; g < NSTG - 1; g++) begin : g_rdy
    assign rdy[g] = !vld_r[g] || rdy[g+1];
  end
  assign in_ready = rdy[0];

  always_comb begin
    unique case (in_side.adc_range)
      RANGE_2V:    mode0_nxt = MODE_K100;
      RANGE_200MV: mode0_nxt = MODE_K10;
      RANGE_20MV:  mode0_nxt = MODE_K1;
      default:     mode0_nxt = MODE_RAW;
    endcase
  end

  always_comb begin
    unique case (mode_r[0])
      MODE_K100: kval = K_2V;
      MODE_K10:  kval = K_200MV;
      MODE_K1:   kval = K_20MV;
      MODE_RAW:  kval = K_20MV;
      default:   kval = K_20MV;
    endcase
  end

  always_comb begin
    prod1_nxt = {7'd0, mag_r[0]} * {32'd0, kval};
    // quotient estimate of prod / 144888, low by at most one
    recip2_p  = {22'd0, prod1_r[PROD_W-1:3]} * {36'd0, RECIP};
    diff3     = (QUO_W+DIV_W)'(prod2_r) - ({{DIV_W{1'b0}}, quo2_r} * {{QUO_W{1'b0}}, DIV_BASE});
    ge4       = rem3_r >= REM_W'(DIV_BASE);
    rmd4      = ge4 ? rem3_r - REM_W'(DIV_BASE) : rem3_r;
    num4_nxt  = NUM_W'({rmd4[DIV_W-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(DIV_HALF);
    recip5_p  = {{RECIP_W{1'b0}}, num4_r[NUM_W-1:3]} * {{ZW{1'b0}}, RECIP};
    diff6     = (EST_W+DIV_W)'(num5_r) -
                ({{DIV_W{1'b0}}, est5_r} * {{EST_W{1'b0}}, DIV_BASE});
    est7      = est6_r + EST_W'(rem6_r >= REM_W'(DIV_BASE));
    qdiv7     = SCALED_W'({quo6_r, {FRAC_BITS{1'b0}}}) + SCALED_W'(est7);
    q7        = (mode_r[6] == MODE_RAW) ? (SCALED_W'(mag_r[6]) << FRAC_BITS) : qdiv7;
    if (q7 > SCALED_MAX_MAG) begin
      q7 = SCALED_MAX_MAG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int unsigned i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mag_r[0]  <= in_mag;
      mode_r[0] <= mode0_nxt;
      side_r[0] <= in_side;
    end
    for (int unsigned i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        mag_r[i]  <= mag_r[i-1];
        mode_r[i] <= mode_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
    if (rdy[1]) begin
      prod1_r <= prod1_nxt;
    end
    if (rdy[2]) begin
      prod2_r <= prod1_r;
      quo2_r  <= recip2_p[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    end
    if (rdy[3]) begin
      quo3_r <= quo2_r;
      rem3_r <= diff3[REM_W-1:0];
    end
    if (rdy[4]) begin
      quo4_r <= quo3_r + QUO_W'(ge4);
      num4_r <= num4_nxt;
    end
    if (rdy[5]) begin
      quo5_r <= quo4_r;
      num5_r <= num4_r;
      est5_r <= recip5_p[RECIP_SHIFT+EST_W-1:RECIP_SHIFT];
    end
    if (rdy[6]) begin
      quo6_r <= quo5_r;
      est6_r <= est5_r;
      rem6_r <= diff6[REM_W-1:0];
    end
    if (rdy[7]) begin
      scaled7_r <= SCALED_W'(0) - q7;
    end
  end

  assign out_valid  = vld_r[NSTG-1];
  assign out_scaled = scaled7_r;
  assign out_count  = COUNT_W'(0) - COUNT_W'(mag_r[NSTG-1]);
  assign out_side   = side_r[NSTG-1];

endmodule

>>> test/meter_frame_decoder_checker.sv
`timescale 1ns / 1ps
// result checker for the meter frame decoder: watches both stream channels,
// predicts each frame result from accepted bytes and compares field by field
// depends on mfd_pkg

module meter_frame_decoder_checker
  import mfd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         out_tuser,
  output int           mismatches,
  output int           awaiting,
  output int           results_seen,
  output int           frames_accepted
);

  typedef struct packed {
    logic        frame_ok;
    logic [32:0] signed_count;
    logic [48:0] scaled_volts;
    logic [7:0]  adc_range;
    logic [7:0]  range_index;
    logic        current_valid;
    logic [7:0]  current_code;
    logic [4:0]  pad;
  } frame_result_t;

  frame_result_t expected_frames[$];
  logic [3:0]    byte_pos;
  logic [7:0]    frame_buf [0:6];
  int            fault_count;
  int            result_count;
  int            good_count;

  initial begin
    mismatches      = 0;
    awaiting        = 0;
    results_seen    = 0;
    frames_accepted = 0;
    fault_count     = 0;
    result_count    = 0;
    good_count      = 0;
    byte_pos        = '0;
  end

  // closes the frame held in frame_buf with its checksum byte
  function automatic frame_result_t decode_frame(input logic [7:0] sum_byte);
    frame_result_t r;
    logic [7:0]    sum;
    logic [31:0]   cnt;
    logic [63:0]   mag;
    logic [63:0]   x;
    logic [63:0]   q;
    int            i;
    r   = '0;
    sum = '0;
    for (i = 0; i < 7; i++) sum = sum + frame_buf[i];
    if (sum != ~sum_byte) return r;
    cnt = {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]};
    mag = (cnt > COUNT_MID) ? 64'(cnt - COUNT_MID) : 64'(COUNT_MID - cnt);
    x   = mag << FRAC_BITS;
    case (frame_buf[4])
      RANGE_2V:    q = (x * K_2V + DIV_HALF) / DIV_BASE;
      RANGE_200MV: q = (x * K_200MV + DIV_HALF) / DIV_BASE;
      RANGE_20MV:  q = (x * K_20MV + DIV_HALF) / DIV_BASE;
      default:     q = x;
    endcase
    if (q > 64'(SCALED_MAX_MAG)) q = 64'(SCALED_MAX_MAG);
    r.frame_ok     = 1'b1;
    r.signed_count = -mag[32:0];
    r.scaled_volts = -q[48:0];
    r.adc_range    = frame_buf[4];
    r.range_index  = frame_buf[5] - 8'd1;
    if (frame_buf[6] >= CURRENT_OFFSET) begin
      r.current_valid = 1'b1;
      r.current_code  = 8'(frame_buf[6] - CURRENT_OFFSET);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fault_count < 40)
      $display("mismatch on result %0d: %s got %0h, wanted %0h",
               result_count, what, got, want);
    fault_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      byte_pos = '0;
      expected_frames.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser) byte_pos = '0;
        if (byte_pos < 4'(FRAME_LEN - 1)) begin
          frame_buf[byte_pos[2:0]] = in_tdata;
          byte_pos++;
        end else if (byte_pos == 4'(FRAME_LEN - 1)) begin
          expected_frames.push_back(decode_frame(in_tdata));
          byte_pos = 4'(FRAME_LEN);
        end
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        got = {out_tuser, out_tdata[32:0], out_tdata[81:33], out_tdata[89:82],
               out_tdata[97:90], out_tdata[98], out_tdata[106:99], out_tdata[111:107]};
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result, frame_ok", 64'(got.frame_ok), 64'(0));
        end else begin
          want = expected_frames.pop_front();
          if (want.frame_ok) good_count++;
          check_field("frame_ok", 64'(got.frame_ok), 64'(want.frame_ok));
          check_field("signed_count", 64'(got.signed_count), 64'(want.signed_count));
          check_field("scaled_volts", 64'(got.scaled_volts), 64'(want.scaled_volts));
          check_field("adc_range", 64'(got.adc_range), 64'(want.adc_range));
          check_field("range_index", 64'(got.range_index), 64'(want.range_index));
          check_field("current_valid", 64'(got.current_valid),
                      64'(want.current_valid));
          check_field("current_code", 64'(got.current_code), 64'(want.current_code));
          check_field("pad", 64'(got.pad), 64'(want.pad));
        end
      end
    end
    mismatches      <= fault_count;
    awaiting        <= expected_frames.size();
    results_seen    <= result_count;
    frames_accepted <= good_count;
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// top of the meter frame decoder testbench: clock, reset, byte stimulus,
// receiver back-pressure and the verdict
// depends on mfd_pkg, meter_frame_decoder_top and meter_frame_decoder_checker

module testbench;
  import mfd_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int          TARGET_BYTES = 1100;
  // slowest run: every byte behind a long sender gap, every result held by
  // sparse ready, plus the divider depth; taken many times over
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 24;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MASK,
    READY_SPARSE
  } ready_mode_t;

  typedef enum logic [1:0] {
    SEQ_GOOD,
    SEQ_BAD_SUM,
    SEQ_CUT,
    SEQ_NOISE
  } seq_kind_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         out_tuser;

  int mismatches;
  int awaiting;
  int results_seen;
  int frames_accepted;
  int bytes_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  ready_mode_t ready_mode  = READY_ALWAYS;
  int          ready_epoch = 0;
  logic [7:0]  ready_mask  = '1;

  initial begin
    forever #5 clk = ~clk;
  end

  meter_frame_decoder_top #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  meter_frame_decoder_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_seen    (results_seen),
    .frames_accepted (frames_accepted)
  );

  // receiver back-pressure: each epoch picks a stall pattern, from always
  // ready through coin flips and a rotating mask to mostly stalled
  always @(posedge clk) begin
    if (ready_epoch == 0) begin
      ready_epoch = $urandom_range(16, 200);
      ready_mode  = ready_mode_t'($urandom_range(0, 3));
      ready_mask  = 8'($urandom);
    end
    ready_epoch--;
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      READY_MASK:   out_tready <= ready_mask[ready_epoch[2:0]];
      default:      out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one byte transfer; the sender runs in bursts with idle gaps between them,
  // and valid stays high across a burst
  task automatic send_byte(input logic [7:0] rx_byte, input logic frame_start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx_byte;
    in_tuser  <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // whole frame, byte 0 in the low bits, start flag on byte 0 only
  task automatic send_frame(input logic [63:0] frame);
    int i;
    for (i = 0; i < 8; i++) send_byte(frame[8*i +: 8], i == 0);
  endtask

  // appends the checksum byte: complement of the sum of bytes 0..6
  function automatic logic [63:0] seal_frame(input logic [55:0] body);
    logic [7:0] sum;
    int         i;
    sum = '0;
    for (i = 0; i < 7; i++) sum = sum + body[8*i +: 8];
    return {~sum, body};
  endfunction

  // random frame content, biased towards counts near the mid-point and the
  // extremes, the three scaled ranges and low current bytes
  function automatic logic [55:0] random_body();
    logic [31:0] cnt;
    logic [7:0]  rng;
    logic [7:0]  b5;
    logic [7:0]  b6;
    case ($urandom_range(0, 3))
      0: cnt = $urandom;
      1: cnt = COUNT_MID + $urandom_range(0, 512) - 256;
      2: begin
        case ($urandom_range(0, 4))
          0:       cnt = '0;
          1:       cnt = '1;
          2:       cnt = COUNT_MID;
          3:       cnt = COUNT_MID + 1;
          default: cnt = COUNT_MID - 1;
        endcase
      end
      default: cnt = {8'h00, 8'($urandom_range(0, 2)), 16'($urandom)};
    endcase
    rng = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    b5  = 8'($urandom);
    b6  = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    return {b6, b5, rng, cnt[7:0], cnt[15:8], cnt[23:16], cnt[31:24]};
  endfunction

  initial begin
    seq_kind_t   kind;
    int          pick;
    int          n;
    int          i;
    logic [63:0] frame;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: largest count on the 2 V range with range byte wrap and
    // current byte just below the offset
    send_frame(seal_frame({8'h02, 8'h00, RANGE_2V, 32'hFFFF_FFFF}));
    // byte past the eighth without start: ignored
    send_byte(8'hFF, 1'b0);
    // partial frame, then a start flag restarts mid-frame; count at the
    // mid-point on an unscaled range, current byte equal to the offset
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_frame(seal_frame({8'h03, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01}));
    // bad checksum on the 200 mV range with zero count and top current byte
    send_frame(seal_frame({8'hFF, 8'h80, RANGE_200MV, 32'h0}) ^ {8'h5A, 56'h0});

    // random: mostly well-formed frames, some broken or cut short, some noise
    while (bytes_sent < TARGET_BYTES) begin
      pick = $urandom_range(0, 19);
      kind = (pick < 14) ? SEQ_GOOD : (pick < 16) ? SEQ_BAD_SUM
           : (pick < 18) ? SEQ_CUT : SEQ_NOISE;
      case (kind)
        SEQ_GOOD: begin
          send_frame(seal_frame(random_body()));
          // trailing bytes after a complete frame
          if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
          end
        end
        SEQ_BAD_SUM: begin
          frame = seal_frame(random_body());
          frame[63:56] = frame[63:56] ^ 8'($urandom_range(1, 255));
          send_frame(frame);
        end
        SEQ_CUT: begin
          frame = seal_frame(random_body());
          n = $urandom_range(1, 7);
          for (i = 0; i < n; i++) send_byte(frame[8*i +: 8], i == 0);
        end
        default: begin
          n = $urandom_range(1, 5);
          for (i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // let the checker see the last transfer, then drain the divider
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d byte transfers and %0d frame results", bytes_sent,
             results_seen);
    $display("of those %0d frames passed the checksum and %0d were rejected",
             frames_accepted, results_seen - frames_accepted);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> meter_frame_decoder_top.f
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_scale.sv
hw/rtl/meter_frame_decoder_top.sv
test/meter_frame_decoder_checker.sv
test/testbench.sv
